/* hw/rtl/encoder_threshold_calibrator_assert.svh */
// Assertion macros shared by the encoder threshold calibrator RTL.
// Each macro expects clk_i and rst_ni to be visible in the using module.
`ifndef ENCODER_THRESHOLD_CALIBRATOR_ASSERT_SVH
`define ENCODER_THRESHOLD_CALIBRATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ETC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ETC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/etc_pkg.sv */
// Package of the encoder threshold calibrator: field widths, phase and action
// codes, register indexes, reset values and the config and control structs. No dependencies.
package etc_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned NUM_W   = 7;
  localparam int unsigned WIN_W   = 16;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned ACT_W   = 3;

  localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
  localparam logic [PHASE_W-1:0] PH_CAL    = 2'd1;
  localparam logic [PHASE_W-1:0] PH_VERIFY = 2'd2;
  localparam logic [PHASE_W-1:0] PH_DONE   = 2'd3;

  localparam logic [ACT_W-1:0] ACT_NONE   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DRIVE  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_BOUNDS = 3'd2;
  localparam logic [ACT_W-1:0] ACT_FINISH = 3'd3;
  localparam logic [ACT_W-1:0] ACT_ROUTE  = 3'd4;

  // Register indexes, decoded from paddr[2].
  localparam logic REG_DEAD_BAND = 1'b0;
  localparam logic REG_WINDOW    = 1'b1;

  localparam int unsigned BAND_DIV = 100;

  localparam logic [NUM_W-1:0] BAND_PCT_RST  = 7'd2;
  localparam logic [WIN_W-1:0] WINDOW_MS_RST = 16'd500;

  typedef struct packed {
    logic [NUM_W-1:0] band_pct;
    logic [WIN_W-1:0] window_ms;
  } etc_cfg_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [ACT_W-1:0]   action;
    logic               derive;
  } etc_ctrl_t;

endpackage

/* hw/rtl/encoder_threshold_calibrator.sv */
// Top level of the encoder threshold calibrator.
// Instantiates etc_cfg, etc_track and two etc_thresh channels; depends on etc_pkg.

// The block takes one beat per clock cycle on the input channel while
// in_stall_o is low, and returns exactly one result beat for each, in order,
// through the input register, sequencer register, two threshold datapath
// stages and result register. The phase sequencer and the min/max trackers
// update once per beat, and the thresholds derived when the calibration
// window closes are held in the result register until reset. Stalls on the
// output propagate back through the pipeline, while empty stages still
// accept new beats. Configuration is read and written through the APB port
// at byte addresses 0 (dead band) and 4 (window length).
`include "encoder_threshold_calibrator_assert.svh"

module encoder_threshold_calibrator #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [etc_pkg::TIME_W-1:0]   now_ms_i,
  input  logic [SAMPLE_BITS-1:0]       left_sample_i,
  input  logic [SAMPLE_BITS-1:0]       right_sample_i,
  input  logic                         verify_done_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [etc_pkg::PHASE_W-1:0]  phase_o,
  output logic [etc_pkg::ACT_W-1:0]    action_o,
  output logic [SAMPLE_BITS-1:0]       left_rise_o,
  output logic [SAMPLE_BITS-1:0]       left_fall_o,
  output logic [SAMPLE_BITS-1:0]       right_rise_o,
  output logic [SAMPLE_BITS-1:0]       right_fall_o
);
  import etc_pkg::*;

  etc_cfg_t  cfg;
  logic      s1_valid;
  etc_ctrl_t s1_ctrl;
  logic [SAMPLE_BITS-1:0] lhi, llo, rhi, rlo;
  logic [SAMPLE_BITS-1:0] lup_new, llo_new, rup_new, rlo_new;

  logic      v2_q, v3_q, out_valid_q;
  etc_ctrl_t ctrl2_q, ctrl3_q;
  logic [PHASE_W-1:0] out_phase_q;
  logic [ACT_W-1:0]   out_action_q;
  logic [SAMPLE_BITS-1:0] left_rise_q, left_fall_q, right_rise_q, right_fall_q;
  logic ld_out, ld3, ld2, take_th;

  assign ld_out  = !out_valid_q || !out_stall_i;
  assign ld3     = !v3_q || ld_out;
  assign ld2     = !v2_q || ld3;
  assign take_th = ld_out && v3_q && ctrl3_q.derive;

  etc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  etc_track #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_track (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .now_ms_i       (now_ms_i),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .verify_done_i  (verify_done_i),
    .window_ms_i    (cfg.window_ms),
    .s1_take_i      (ld2),
    .s1_valid_o     (s1_valid),
    .s1_ctrl_o      (s1_ctrl),
    .left_hi_o      (lhi),
    .left_lo_o      (llo),
    .right_hi_o     (rhi),
    .right_lo_o     (rlo)
  );

  etc_thresh #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_thresh_left (
    .clk_i      (clk_i),
    .ld2_i      (ld2),
    .ld3_i      (ld3),
    .hi_i       (lhi),
    .lo_i       (llo),
    .band_pct_i (cfg.band_pct),
    .upper_o    (lup_new),
    .lower_o    (llo_new)
  );

  etc_thresh #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_thresh_right (
    .clk_i      (clk_i),
    .ld2_i      (ld2),
    .ld3_i      (ld3),
    .hi_i       (rhi),
    .lo_i       (rlo),
    .band_pct_i (cfg.band_pct),
    .upper_o    (rup_new),
    .lower_o    (rlo_new)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q         <= 1'b0;
      v3_q         <= 1'b0;
      out_valid_q  <= 1'b0;
      left_rise_q  <= '0;
      left_fall_q  <= '0;
      right_rise_q <= '0;
      right_fall_q <= '0;
    end else begin
      if (ld2) begin
        v2_q <= s1_valid;
      end
      if (ld3) begin
        v3_q <= v2_q;
      end
      if (ld_out) begin
        out_valid_q <= v3_q;
      end
      // The result register doubles as the held threshold store.
      if (take_th) begin
        left_rise_q  <= lup_new;
        left_fall_q  <= llo_new;
        right_rise_q <= rup_new;
        right_fall_q <= rlo_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld2) begin
      ctrl2_q <= s1_ctrl;
    end
    if (ld3) begin
      ctrl3_q <= ctrl2_q;
    end
    if (ld_out) begin
      out_phase_q  <= ctrl3_q.phase;
      out_action_q <= ctrl3_q.action;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign phase_o      = out_phase_q;
  assign action_o     = out_action_q;
  assign left_rise_o  = left_rise_q;
  assign left_fall_o  = left_fall_q;
  assign right_rise_o = right_rise_q;
  assign right_fall_o = right_fall_q;

  `ETC_ASSERT_IMP(a_th_on_bounds, !$stable(left_rise_q) || !$stable(left_fall_q) ||
                  !$stable(right_rise_q) || !$stable(right_fall_q),
                  out_valid_q && out_action_q == ACT_BOUNDS, "thresholds moved off a bounds beat")
  `ETC_ASSERT_IMP(a_band_order, out_valid_q && out_action_q == ACT_BOUNDS,
                  left_rise_q >= left_fall_q && right_rise_q >= right_fall_q,
                  "upper threshold below lower threshold")

endmodule

/* hw/rtl/etc_cfg.sv */
// Configuration registers of the encoder threshold calibrator behind an
// APB-style port. Depends on etc_pkg.
module etc_cfg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output etc_pkg::etc_cfg_t cfg_o
);
  import etc_pkg::*;

  logic [NUM_W-1:0] dead_band_q, dead_band_d;
  logic [WIN_W-1:0] window_q, window_d;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    dead_band_d = dead_band_q;
    window_d    = window_q;
    if (wr_en) begin
      case (paddr[2])
        REG_DEAD_BAND: dead_band_d = pwdata[NUM_W-1:0];
        REG_WINDOW:    window_d    = pwdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DEAD_BAND: prdata = 32'(dead_band_q);
      REG_WINDOW:    prdata = 32'(window_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_band_q <= BAND_PCT_RST;
      window_q    <= WINDOW_MS_RST;
    end else begin
      dead_band_q <= dead_band_d;
      window_q    <= window_d;
    end
  end

  assign cfg_o.band_pct  = dead_band_q;
  assign cfg_o.window_ms = window_q;

endmodule

/* hw/rtl/etc_track.sv */
// Input register, phase sequencer and min/max tracking of the calibrator.
// Produces one registered control word per beat. Depends on etc_pkg.
`include "encoder_threshold_calibrator_assert.svh"

module etc_track #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [etc_pkg::TIME_W-1:0] now_ms_i,
  input  logic [SAMPLE_BITS-1:0]     left_sample_i,
  input  logic [SAMPLE_BITS-1:0]     right_sample_i,
  input  logic                       verify_done_i,
  input  logic [etc_pkg::WIN_W-1:0]  window_ms_i,
  input  logic                       s1_take_i,
  output logic                       s1_valid_o,
  output etc_pkg::etc_ctrl_t         s1_ctrl_o,
  output logic [SAMPLE_BITS-1:0]     left_hi_o,
  output logic [SAMPLE_BITS-1:0]     left_lo_o,
  output logic [SAMPLE_BITS-1:0]     right_hi_o,
  output logic [SAMPLE_BITS-1:0]     right_lo_o
);
  import etc_pkg::*;

  // Input register.
  logic                   s0_valid_q;
  logic [TIME_W-1:0]      s0_now_q;
  logic [SAMPLE_BITS-1:0] s0_left_q, s0_right_q;
  logic                   s0_done_q;

  // Calibration state.
  logic [PHASE_W-1:0]     phase_q, phase_d;
  logic [TIME_W-1:0]      start_q, start_d;
  logic [SAMPLE_BITS-1:0] lmax_q, lmax_d, lmin_q, lmin_d;
  logic [SAMPLE_BITS-1:0] rmax_q, rmax_d, rmin_q, rmin_d;

  // Tracked extremes including the sample of the current beat.
  logic [SAMPLE_BITS-1:0] lmax_t, lmin_t, rmax_t, rmin_t;
  logic [TIME_W-1:0]      elapsed;

  logic      s1_valid_q;
  etc_ctrl_t s1_ctrl_q, ctrl_d;
  logic [SAMPLE_BITS-1:0] lhi_q, llo_q, rhi_q, rlo_q;

  logic ld0, ld1, step;

  assign ld1        = !s1_valid_q || s1_take_i;
  assign ld0        = !s0_valid_q || ld1;
  assign step       = s0_valid_q && ld1;
  assign in_stall_o = !ld0;

  assign lmax_t  = (s0_left_q > lmax_q) ? s0_left_q : lmax_q;
  assign lmin_t  = (s0_left_q < lmin_q) ? s0_left_q : lmin_q;
  assign rmax_t  = (s0_right_q > rmax_q) ? s0_right_q : rmax_q;
  assign rmin_t  = (s0_right_q < rmin_q) ? s0_right_q : rmin_q;
  assign elapsed = s0_now_q - start_q;

  always_comb begin
    phase_d       = phase_q;
    start_d       = start_q;
    lmax_d        = lmax_q;
    lmin_d        = lmin_q;
    rmax_d        = rmax_q;
    rmin_d        = rmin_q;
    ctrl_d.action = ACT_NONE;
    ctrl_d.derive = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        start_d       = s0_now_q;
        phase_d       = PH_CAL;
        ctrl_d.action = ACT_DRIVE;
      end
      PH_CAL: begin
        lmax_d = lmax_t;
        lmin_d = lmin_t;
        rmax_d = rmax_t;
        rmin_d = rmin_t;
        // The elapsed time wraps with the tick counter.
        if (elapsed >= TIME_W'(window_ms_i)) begin
          start_d       = s0_now_q;
          phase_d       = PH_VERIFY;
          ctrl_d.action = ACT_BOUNDS;
          ctrl_d.derive = 1'b1;
        end
      end
      PH_VERIFY: begin
        if (s0_done_q) begin
          phase_d       = PH_DONE;
          ctrl_d.action = ACT_FINISH;
        end else begin
          ctrl_d.action = ACT_ROUTE;
        end
      end
      default: ;
    endcase
    ctrl_d.phase = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      phase_q    <= PH_IDLE;
      start_q    <= '0;
      lmax_q     <= '0;
      lmin_q     <= '1;
      rmax_q     <= '0;
      rmin_q     <= '1;
    end else begin
      if (ld0) begin
        s0_valid_q <= in_valid_i;
      end
      if (ld1) begin
        s1_valid_q <= s0_valid_q;
      end
      if (step) begin
        phase_q <= phase_d;
        start_q <= start_d;
        lmax_q  <= lmax_d;
        lmin_q  <= lmin_d;
        rmax_q  <= rmax_d;
        rmin_q  <= rmin_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld0) begin
      s0_now_q   <= now_ms_i;
      s0_left_q  <= left_sample_i;
      s0_right_q <= right_sample_i;
      s0_done_q  <= verify_done_i;
    end
    if (ld1) begin
      s1_ctrl_q <= ctrl_d;
      lhi_q     <= lmax_t;
      llo_q     <= lmin_t;
      rhi_q     <= rmax_t;
      rlo_q     <= rmin_t;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_ctrl_o  = s1_ctrl_q;
  assign left_hi_o  = lhi_q;
  assign left_lo_o  = llo_q;
  assign right_hi_o = rhi_q;
  assign right_lo_o = rlo_q;

  `ETC_ASSERT_NEXT(a_done_final, phase_q == PH_DONE, phase_q == PH_DONE, "calibrated phase left")
  `ETC_ASSERT_IMP(a_phase_on_beat, !$stable(phase_q), $past(step), "phase moved without a beat")
  `ETC_ASSERT_IMP(a_bounds_ordered, phase_q == PH_VERIFY || phase_q == PH_DONE,
                  lmin_q <= lmax_q && rmin_q <= rmax_q, "bounds inverted after calibration")

endmodule

/* hw/rtl/etc_thresh.sv */
// Threshold datapath of one encoder channel: midpoint, dead-band product and
// division by the dead-band denominator over two register stages. Depends on etc_pkg.
module etc_thresh #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                      clk_i,
  input  logic                      ld2_i,
  input  logic                      ld3_i,
  input  logic [SAMPLE_BITS-1:0]    hi_i,
  input  logic [SAMPLE_BITS-1:0]    lo_i,
  input  logic [etc_pkg::NUM_W-1:0] band_pct_i,
  output logic [SAMPLE_BITS-1:0]    upper_o,
  output logic [SAMPLE_BITS-1:0]    lower_o
);
  import etc_pkg::*;

  localparam int unsigned SW          = SAMPLE_BITS;
  localparam int unsigned PW          = SW + 8;
  localparam int unsigned PW2         = 2 * PW;
  localparam int unsigned QW          = PW - 6;
  localparam int unsigned UW          = QW + 1;
  localparam int unsigned RECIP_SHIFT = PW + 6;
  localparam int unsigned RECIP_MUL   = (32'd1 << RECIP_SHIFT) / BAND_DIV;
  localparam int unsigned ROUND_ADD   = BAND_DIV / 2;
  localparam logic [SW-1:0] SAMPLE_MAX = '1;

  logic [SW-1:0]  top_v, bot_v, avg_v, du, dl;
  logic [SW:0]    sum_v;
  logic [PW-1:0]  pu_d, pl_d;
  logic [SW-1:0]  avg2_q;
  logic [PW-1:0]  pu2_q, pl2_q;
  logic [PW2-1:0] prod_u, prod_l;
  logic [SW-1:0]  avg3_q;
  logic [PW-1:0]  pu3_q, pl3_q;
  logic [QW-1:0]  qu3_q, ql3_q;
  logic [PW-1:0]  ru, rl;
  logic [QW-1:0]  qu, ql;
  logic [QW:0]    up_sum;

  // Stage two: midpoint and rounded dead-band products.
  always_comb begin
    if (hi_i < lo_i) begin
      top_v = lo_i;
      bot_v = hi_i;
    end else begin
      top_v = hi_i;
      bot_v = lo_i;
    end
    sum_v = {1'b0, top_v} + {1'b0, bot_v};
    avg_v = sum_v[SW:1];
    du    = top_v - avg_v;
    dl    = avg_v - bot_v;
    pu_d  = PW'(du) * PW'(band_pct_i) + PW'(ROUND_ADD);
    pl_d  = PW'(dl) * PW'(band_pct_i) + PW'(ROUND_ADD);
  end

  // Stage three: reciprocal estimate of the quotient, low by at most one.
  assign prod_u = PW2'(pu2_q) * PW2'(RECIP_MUL);
  assign prod_l = PW2'(pl2_q) * PW2'(RECIP_MUL);

  always_ff @(posedge clk_i) begin
    if (ld2_i) begin
      avg2_q <= avg_v;
      pu2_q  <= pu_d;
      pl2_q  <= pl_d;
    end
    if (ld3_i) begin
      avg3_q <= avg2_q;
      pu3_q  <= pu2_q;
      pl3_q  <= pl2_q;
      qu3_q  <= prod_u[RECIP_SHIFT +: QW];
      ql3_q  <= prod_l[RECIP_SHIFT +: QW];
    end
  end

  // Final correction of the quotient, then saturation to the sample range.
  always_comb begin
    ru     = pu3_q - PW'(qu3_q) * PW'(BAND_DIV);
    rl     = pl3_q - PW'(ql3_q) * PW'(BAND_DIV);
    qu     = qu3_q + QW'(ru >= PW'(BAND_DIV));
    ql     = ql3_q + QW'(rl >= PW'(BAND_DIV));
    up_sum = UW'(avg3_q) + UW'(qu);
    if (up_sum > UW'(SAMPLE_MAX)) begin
      upper_o = SAMPLE_MAX;
    end else begin
      upper_o = up_sum[SW-1:0];
    end
    if (ql > QW'(avg3_q)) begin
      lower_o = '0;
    end else begin
      lower_o = avg3_q - ql[SW-1:0];
    end
  end

endmodule

/* dv/encoder_threshold_calibrator_chk.sv */
// Scoreboard for the encoder threshold calibrator: watches the APB port and both
// beat channels, predicts every result beat and compares it field by field.
// Depends on etc_pkg for widths, phase and action codes and register indexes.
`timescale 1ns / 100ps

module encoder_threshold_calibrator_chk #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  input  logic                         pready,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [etc_pkg::TIME_W-1:0]   now_ms_i,
  input  logic [SAMPLE_BITS-1:0]       left_sample_i,
  input  logic [SAMPLE_BITS-1:0]       right_sample_i,
  input  logic                         verify_done_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [etc_pkg::PHASE_W-1:0]  phase_i,
  input  logic [etc_pkg::ACT_W-1:0]    action_i,
  input  logic [SAMPLE_BITS-1:0]       left_rise_i,
  input  logic [SAMPLE_BITS-1:0]       left_fall_i,
  input  logic [SAMPLE_BITS-1:0]       right_rise_i,
  input  logic [SAMPLE_BITS-1:0]       right_fall_i,
  output int                           fails_o,
  output int                           backlog_o
);
  import etc_pkg::*;

  localparam int unsigned SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [ACT_W-1:0]   action;
    sample_t            left_rise;
    sample_t            left_fall;
    sample_t            right_rise;
    sample_t            right_fall;
  } cal_result_t;

  cal_result_t        awaited_results[$];
  int                 mismatches = 0;
  int                 backlog = 0;

  logic [NUM_W-1:0]   dead_band;
  logic [WIN_W-1:0]   window_len;
  logic [PHASE_W-1:0] cal_phase;
  logic [TIME_W-1:0]  window_origin;
  sample_t            left_hi, left_lo, right_hi, right_lo;
  sample_t            bounds [4];

  assign fails_o   = mismatches;
  assign backlog_o = backlog;

  // Schmitt thresholds from the tracked extremes, with saturation at both rails.
  function automatic void schmitt_bounds(input sample_t hi_in, input sample_t lo_in,
                                         output sample_t up, output sample_t dn);
    int unsigned hi, lo, mid, up_step, dn_step, peak;
    hi = hi_in;
    lo = lo_in;
    if (hi < lo) begin
      peak = hi;
      hi = lo;
      lo = peak;
    end
    mid = (hi + lo) / 2;
    up_step = ((hi - mid) * dead_band + BAND_DIV / 2) / BAND_DIV;
    dn_step = ((mid - lo) * dead_band + BAND_DIV / 2) / BAND_DIV;
    peak = mid + up_step;
    up = (peak > SAMPLE_MAX) ? sample_t'(SAMPLE_MAX) : sample_t'(peak);
    dn = (dn_step > mid) ? '0 : sample_t'(mid - dn_step);
  endfunction

  function automatic cal_result_t advance_calibration(input logic [TIME_W-1:0] now,
                                                      input sample_t ls, input sample_t rs,
                                                      input logic done);
    cal_result_t       res;
    logic [TIME_W-1:0] elapsed;
    res.action = ACT_NONE;
    case (cal_phase)
      PH_IDLE: begin
        window_origin = now;
        cal_phase = PH_CAL;
        res.action = ACT_DRIVE;
      end
      PH_CAL: begin
        if (ls > left_hi) left_hi = ls;
        if (ls < left_lo) left_lo = ls;
        if (rs > right_hi) right_hi = rs;
        if (rs < right_lo) right_lo = rs;
        // The tick wraps, so the elapsed time is taken modulo 2^32.
        elapsed = now - window_origin;
        if (elapsed >= TIME_W'(window_len)) begin
          window_origin = now;
          schmitt_bounds(left_hi, left_lo, bounds[0], bounds[1]);
          schmitt_bounds(right_hi, right_lo, bounds[2], bounds[3]);
          cal_phase = PH_VERIFY;
          res.action = ACT_BOUNDS;
        end
      end
      PH_VERIFY: begin
        if (done) begin
          cal_phase = PH_DONE;
          res.action = ACT_FINISH;
        end else begin
          res.action = ACT_ROUTE;
        end
      end
      default: ;
    endcase
    res.phase      = cal_phase;
    res.left_rise  = bounds[0];
    res.left_fall  = bounds[1];
    res.right_rise = bounds[2];
    res.right_fall = bounds[3];
    return res;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cal_result_t head;
    if (!rst_ni) begin
      dead_band     = BAND_PCT_RST;
      window_len    = WINDOW_MS_RST;
      cal_phase     = PH_IDLE;
      window_origin = '0;
      left_hi       = '0;
      left_lo       = sample_t'(SAMPLE_MAX);
      right_hi      = '0;
      right_lo      = sample_t'(SAMPLE_MAX);
      for (int i = 0; i < 4; i++) bounds[i] = '0;
      awaited_results.delete();
      backlog <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_WINDOW) window_len = pwdata[WIN_W-1:0];
        else dead_band = pwdata[NUM_W-1:0];
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_results.push_back(advance_calibration(now_ms_i, left_sample_i,
                                                      right_sample_i, verify_done_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $error("result beat arrived with no expectation waiting");
          mismatches++;
        end else begin
          head = awaited_results.pop_front();
          check_field("phase", head.phase, phase_i);
          check_field("action", head.action, action_i);
          check_field("left_rise", head.left_rise, left_rise_i);
          check_field("left_fall", head.left_fall, left_fall_i);
          check_field("right_rise", head.right_rise, right_rise_i);
          check_field("right_fall", head.right_fall, right_fall_i);
        end
      end
      backlog <= awaited_results.size();
    end
  end

endmodule

/* dv/encoder_threshold_calibrator_tb.sv */
// Testbench top of the encoder threshold calibrator: clock, reset, APB writes,
// input beats and output stalls. Depends on etc_pkg, the RTL and the scoreboard.
`timescale 1ns / 100ps

module encoder_threshold_calibrator_tb;
  import etc_pkg::*;

  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
  localparam int unsigned BEATS       = 1350;
  localparam int unsigned LIMIT       = 200000;
  localparam int unsigned DRAIN       = 12;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [2:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [TIME_W-1:0]    now_ms = '0;
  sample_t              left_sample = '0;
  sample_t              right_sample = '0;
  logic                 verify_done = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PHASE_W-1:0]   phase;
  logic [ACT_W-1:0]     action;
  sample_t              left_rise, left_fall, right_rise, right_fall;

  int                   fails;
  int                   backlog;
  logic                 quiet = 1'b0;
  int unsigned          cycles = 0;
  int unsigned          sent = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic sample_t rand_sample();
    return sample_t'($urandom_range(0, SAMPLE_MAX));
  endfunction

  task automatic reg_write(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Presents one beat after a random number of idle cycles and returns at the
  // edge on which it is taken, leaving valid high for the next call.
  task automatic send_beat(input logic [TIME_W-1:0] t, input sample_t ls,
                           input sample_t rs, input logic done);
    while (!quiet && $urandom_range(0, 99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    now_ms       <= t;
    left_sample  <= ls;
    right_sample <= rs;
    verify_done  <= done;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sent++;
  endtask

  // Holds off the sender until every expected result beat has been returned.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (backlog != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  initial begin
    logic [TIME_W-1:0] origin;
    int                n;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    reg_write(REG_DEAD_BAND, 32'd0);
    reg_write(REG_WINDOW, 32'hFFFF);

    // Start the window close to the top of the tick range so that many
    // calibration beats see the tick wrap.
    origin = 32'hFFFF_0000 | TIME_W'($urandom_range(1, 16'hFFFF));
    // The opening beat only records the start; its samples and flag are ignored.
    send_beat(origin, sample_t'(SAMPLE_MAX), '0, 1'b1);
    send_beat(origin + 32'd65534, '0, sample_t'(SAMPLE_MAX), 1'b1);
    send_beat(origin + 32'd65534, sample_t'(SAMPLE_MAX), '0, 1'b0);
    send_beat(origin, 12'hAAA, 12'h555, 1'b1);
    send_beat(origin + 32'd1, 12'h555, 12'hAAA, 1'b0);
    settle();

    // A window of one stays open while the tick equals the start.
    reg_write(REG_WINDOW, 32'd1);
    repeat (4) send_beat(origin, rand_sample(), rand_sample(), 1'($urandom_range(0, 1)));
    settle();
    reg_write(REG_DEAD_BAND, 32'd100);
    reg_write(REG_WINDOW, 32'hFFFF);

    for (n = 0; n < 800; n++) begin
      if (n == 300) quiet <= 1'b1;
      if (n == 500) quiet <= 1'b0;
      if (n == 650) begin
        settle();
        reg_write(REG_DEAD_BAND, 32'($urandom_range(0, 127)));
      end
      send_beat(origin + TIME_W'($urandom_range(0, 65534)), rand_sample(), rand_sample(),
                1'($urandom_range(0, 1)));
    end
    settle();

    // A zero window closes on the next beat; with the full-scale extremes seen
    // earlier, a dead band above a hundred drives both thresholds to the rails.
    reg_write(REG_DEAD_BAND, 32'd127);
    reg_write(REG_WINDOW, 32'd0);
    send_beat(origin, rand_sample(), rand_sample(), 1'b0);

    for (n = 0; n < 200; n++) send_beat($urandom(), rand_sample(), rand_sample(), 1'b0);
    send_beat($urandom(), rand_sample(), rand_sample(), 1'b1);
    settle();

    reg_write(REG_WINDOW, 32'($urandom_range(1, 65535)));
    reg_write(REG_DEAD_BAND, 32'($urandom_range(0, 100)));
    while (sent < BEATS)
      send_beat($urandom(), rand_sample(), rand_sample(), 1'($urandom_range(0, 1)));

    settle();
    if (fails == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  always @(posedge clk_i) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 22);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  encoder_threshold_calibrator #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .now_ms_i       (now_ms),
    .left_sample_i  (left_sample),
    .right_sample_i (right_sample),
    .verify_done_i  (verify_done),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .phase_o        (phase),
    .action_o       (action),
    .left_rise_o    (left_rise),
    .left_fall_o    (left_fall),
    .right_rise_o   (right_rise),
    .right_fall_o   (right_fall)
  );

  encoder_threshold_calibrator_chk #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .now_ms_i       (now_ms),
    .left_sample_i  (left_sample),
    .right_sample_i (right_sample),
    .verify_done_i  (verify_done),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .phase_i        (phase),
    .action_i       (action),
    .left_rise_i    (left_rise),
    .left_fall_i    (left_fall),
    .right_rise_i   (right_rise),
    .right_fall_i   (right_fall),
    .fails_o        (fails),
    .backlog_o      (backlog)
  );

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/etc_pkg.sv
hw/rtl/etc_cfg.sv
hw/rtl/etc_track.sv
hw/rtl/etc_thresh.sv
hw/rtl/encoder_threshold_calibrator.sv
dv/encoder_threshold_calibrator_chk.sv
dv/encoder_threshold_calibrator_tb.sv
